>>> hw/rtl/amc_pkg.sv
// ----------------------------------------------------------------------------
// amc_pkg
// shared types, codes and decode helpers of the accumulator machine core
// ----------------------------------------------------------------------------
package amc_pkg;

    localparam int WORD_W        = 32;
    localparam int ADDR_W        = 7;
    localparam int MODE_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int OPC_W         = 6;
    localparam int MEM_WORDS_DEF = 100;

    // accumulator guard band for arithmetic
    localparam int ACC_LIMIT = 9999;

    // decimal split of an instruction word: opcode = word / 100, operand = word % 100
    localparam int DEC_BASE  = 100;
    localparam int DEC_W     = 13;
    localparam int DEC_RECIP = 5243;
    localparam int DEC_SHIFT = 19;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE   = 2'd0,
        MODE_STEP    = 2'd1,
        MODE_PEEK    = 2'd2,
        MODE_RESTART = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_OUTPUT   = 3'd1,
        ST_HALTED   = 3'd2,
        ST_BADOP    = 3'd3,
        ST_DIVZERO  = 3'd4,
        ST_OVERFLOW = 3'd5,
        ST_STOPPED  = 3'd6,
        ST_RANGE    = 3'd7
    } t_status;

    localparam logic [OPC_W-1:0] OP_NONE   = 6'd0;
    localparam logic [OPC_W-1:0] OP_READ   = 6'd10;
    localparam logic [OPC_W-1:0] OP_WRITE  = 6'd11;
    localparam logic [OPC_W-1:0] OP_LOAD   = 6'd20;
    localparam logic [OPC_W-1:0] OP_STORE  = 6'd21;
    localparam logic [OPC_W-1:0] OP_ADD    = 6'd30;
    localparam logic [OPC_W-1:0] OP_SUB    = 6'd31;
    localparam logic [OPC_W-1:0] OP_DIV    = 6'd32;
    localparam logic [OPC_W-1:0] OP_MUL    = 6'd33;
    localparam logic [OPC_W-1:0] OP_BRANCH = 6'd40;
    localparam logic [OPC_W-1:0] OP_BRNEG  = 6'd41;
    localparam logic [OPC_W-1:0] OP_BRZERO = 6'd42;
    localparam logic [OPC_W-1:0] OP_HALT   = 6'd43;

    // words outside this window decode to an unknown opcode
    localparam logic signed [WORD_W-1:0] WORD_LO = WORD_W'(int'(OP_READ) * DEC_BASE);
    localparam logic signed [WORD_W-1:0] WORD_HI = WORD_W'((int'(OP_HALT) + 1) * DEC_BASE - 1);

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic [OPC_W-1:0]  opc;
        logic [ADDR_W-1:0] opa;
    } t_dec;

    // split a word known to lie in WORD_LO..WORD_HI; reciprocal is exact below 43690
    function automatic t_dec dec_split(input logic [DEC_W-1:0] w);
        logic [2*DEC_W-1:0] p;
        logic [OPC_W-1:0]   q;
        logic [DEC_W-1:0]   q100;
        logic [DEC_W-1:0]   rem;
        t_dec               d;
        p    = (2*DEC_W)'(w) * (2*DEC_W)'(DEC_RECIP);
        q    = p[DEC_SHIFT +: OPC_W];
        // q * 100 as q*64 + q*32 + q*4
        q100 = (DEC_W'(q) << 6) + (DEC_W'(q) << 5) + (DEC_W'(q) << 2);
        rem  = w - q100;
        d.opc = q;
        d.opa = rem[ADDR_W-1:0];
        return d;
    endfunction

endpackage

>>> hw/rtl/amc_ram.sv
// ----------------------------------------------------------------------------
// amc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module amc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/amc_alu.sv
// ----------------------------------------------------------------------------
// amc_alu
// iterative arithmetic unit: one shared adder for add, subtract,
// shift-add multiply and restoring divide
// ----------------------------------------------------------------------------
module amc_alu
    import amc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_done,
    output logic [WORD_W-1:0] o_result
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam int SUM_W = WORD_W + 2;

    typedef enum logic [6:0] {
        A_IDLE = 7'b000_0001,
        A_MUL  = 7'b000_0010,
        A_ABSA = 7'b000_0100,
        A_ABSB = 7'b000_1000,
        A_DIV  = 7'b001_0000,
        A_SIGN = 7'b010_0000,
        A_DONE = 7'b100_0000
    } t_alu_state;

    t_alu_state        r_st;
    logic [CNT_W-1:0]  r_cnt;
    logic [WORD_W-1:0] r_acc;
    logic [WORD_W-1:0] r_opa;
    logic [WORD_W-1:0] r_opb;
    logic [WORD_W-1:0] r_rem;
    logic              r_neg;

    logic [SUM_W-1:0]  add_x;
    logic [SUM_W-1:0]  add_y;
    logic              add_sub;
    logic [SUM_W-1:0]  add_sum;
    logic [WORD_W:0]   div_sh;
    logic              div_ge;

    assign div_sh = {r_rem, r_opa[WORD_W-1]};

    // operand select for the shared adder
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        unique case (r_st)
            A_IDLE: begin
                add_x   = {2'b00, i_a};
                add_y   = {2'b00, i_b};
                add_sub = (i_req.op == ALU_SUB);
            end
            A_MUL: begin
                add_x = {2'b00, r_acc};
                add_y = r_opb[0] ? {2'b00, r_opa} : '0;
            end
            A_ABSA, A_SIGN: begin
                add_y   = {2'b00, r_opa};
                add_sub = 1'b1;
            end
            A_ABSB: begin
                add_y   = {2'b00, r_opb};
                add_sub = 1'b1;
            end
            A_DIV: begin
                add_x   = {1'b0, div_sh};
                add_y   = {2'b00, r_opb};
                add_sub = 1'b1;
            end
            A_DONE: begin
                add_x = '0;
            end
            default: begin
                add_x = '0;
            end
        endcase
    end

    assign add_sum = add_x + (add_sub ? ~add_y : add_y) + SUM_W'(add_sub);
    assign div_ge  = ~add_sum[SUM_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            unique case (r_st)
                A_IDLE: begin
                    if (i_req.start) begin
                        unique case (i_req.op)
                            ALU_ADD, ALU_SUB: r_st <= A_DONE;
                            ALU_MUL:          r_st <= A_MUL;
                            ALU_DIV:          r_st <= A_ABSA;
                            default:          r_st <= A_IDLE;
                        endcase
                    end
                end
                A_MUL:   r_st <= (r_cnt == '0) ? A_DONE : A_MUL;
                A_ABSA:  r_st <= A_ABSB;
                A_ABSB:  r_st <= A_DIV;
                A_DIV:   r_st <= (r_cnt == '0) ? A_SIGN : A_DIV;
                A_SIGN:  r_st <= A_DONE;
                A_DONE:  r_st <= A_IDLE;
                default: r_st <= A_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            A_IDLE: begin
                if (i_req.start) begin
                    r_acc <= (i_req.op == ALU_MUL) ? '0 : add_sum[WORD_W-1:0];
                    r_opa <= i_a;
                    r_opb <= i_b;
                    r_rem <= '0;
                    r_neg <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
                    r_cnt <= CNT_W'(WORD_W - 1);
                end
            end
            A_MUL: begin
                r_acc <= add_sum[WORD_W-1:0];
                r_opa <= {r_opa[WORD_W-2:0], 1'b0};
                r_opb <= {1'b0, r_opb[WORD_W-1:1]};
                r_cnt <= r_cnt - 1'b1;
            end
            A_ABSA: begin
                if (r_opa[WORD_W-1]) begin
                    r_opa <= add_sum[WORD_W-1:0];
                end
            end
            A_ABSB: begin
                if (r_opb[WORD_W-1]) begin
                    r_opb <= add_sum[WORD_W-1:0];
                end
            end
            A_DIV: begin
                r_rem <= div_ge ? add_sum[WORD_W-1:0] : div_sh[WORD_W-1:0];
                r_opa <= {r_opa[WORD_W-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            A_SIGN: begin
                r_acc <= r_neg ? add_sum[WORD_W-1:0] : r_opa;
            end
            A_DONE: begin
                r_acc <= r_acc;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_done   = (r_st == A_DONE);
    assign o_result = r_acc;

endmodule

>>> hw/rtl/accumulator_machine_core_unit.sv
// ----------------------------------------------------------------------------
// accumulator_machine_core_unit
// decimal accumulator machine: memory load/peek, restart and single step
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries one command per
//   transaction: i_mode selects write word, step one instruction, peek word
//   or restart; i_address and i_data go with it
//   output channel (o_out_valid / i_out_ready) returns exactly one result
//   transaction per command: status, output value, program counter and
//   accumulator as they stand after the command
// command paths, accept to next accept, result registered on return to idle:
//   write word, restart and a step that stops at once go straight to done;
//   peek adds a peek state; other steps fetch, decode, execute; load, write
//   and arithmetic add an operand state and arithmetic an alu wait; multiply
//   and divide run one bit per cycle over the 32-bit word in the shared unit
// reset: accumulator and program counter cleared, machine running,
//   every memory word reads as zero at once through per-word valid bits,
//   no clearing pass
// stall: a finished result sits in the output register; the next command
//   is still taken and runs, and only its hand-off waits for the register
// ----------------------------------------------------------------------------
module accumulator_machine_core_unit
    import amc_pkg::*;
#(
    parameter int MEMORY_WORDS = MEM_WORDS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [ADDR_W-1:0]        i_address,
    input  logic signed [WORD_W-1:0] i_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic signed [WORD_W-1:0] o_out_value,
    output logic [ADDR_W-1:0]        o_program_counter,
    output logic signed [WORD_W-1:0] o_accumulator_now
);

    localparam int                MA_W   = $clog2(MEMORY_WORDS);
    localparam logic [ADDR_W-1:0] MW_LIM = ADDR_W'(MEMORY_WORDS);
    localparam logic signed [WORD_W-1:0] ACC_HI = WORD_W'(ACC_LIMIT);
    localparam logic signed [WORD_W-1:0] ACC_LO = WORD_W'(-ACC_LIMIT);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PEEK   = 8'b0000_0010,
        S_FETCH  = 8'b0000_0100,
        S_DECODE = 8'b0000_1000,
        S_EXEC   = 8'b0001_0000,
        S_OPER   = 8'b0010_0000,
        S_ALU    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    // sequencer and architectural state
    t_state                r_state,  n_state;
    logic [ADDR_W-1:0]     r_pc,     n_pc;
    logic [WORD_W-1:0]     r_acc,    n_acc;
    logic                  r_run,    n_run;
    logic [MEMORY_WORDS-1:0] r_vld,  n_vld;

    // per-transaction working registers
    logic [WORD_W-1:0]     r_data,   n_data;
    logic [WORD_W-1:0]     r_word,   n_word;
    logic [OPC_W-1:0]      r_opc,    n_opc;
    logic [ADDR_W-1:0]     r_opa,    n_opa;
    t_status               r_status, n_status;
    logic [WORD_W-1:0]     r_outv,   n_outv;
    logic                  r_rd_vld;

    // output register
    logic                  r_out_valid;
    t_status               r_o_status;
    logic [WORD_W-1:0]     r_o_value;
    logic [ADDR_W-1:0]     r_o_pc;
    logic [WORD_W-1:0]     r_o_acc;
    logic                  out_load;

    // memory and alu hookup
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;
    logic [WORD_W-1:0]     mem_word;
    t_alu_req              alu_req;
    logic [WORD_W-1:0]     alu_b;
    logic                  alu_done;
    logic [WORD_W-1:0]     alu_result;

    // decode helpers
    logic                  word_ok;
    t_dec                  dec;
    logic                  is_mem_op;
    logic                  acc_big;
    logic [ADDR_W-1:0]     pc_inc;

    amc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEMORY_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[MA_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[MA_W-1:0]),
        .o_rdata (ram_rdata)
    );

    amc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_acc),
        .i_b      (alu_b),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    // never-written words read as zero
    assign mem_word = r_rd_vld ? ram_rdata : '0;

    assign word_ok = ($signed(r_word) >= WORD_LO) && ($signed(r_word) <= WORD_HI);
    assign dec     = dec_split(r_word[DEC_W-1:0]);

    assign is_mem_op = (r_opc == OP_READ) || (r_opc == OP_WRITE) || (r_opc == OP_LOAD) ||
                       (r_opc == OP_STORE) || (r_opc == OP_ADD) || (r_opc == OP_SUB) ||
                       (r_opc == OP_DIV) || (r_opc == OP_MUL);

    assign acc_big = ($signed(r_acc) > ACC_HI) || ($signed(r_acc) < ACC_LO);
    assign pc_inc  = r_pc + 1'b1;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state   = r_state;
        n_pc      = r_pc;
        n_acc     = r_acc;
        n_run     = r_run;
        n_vld     = r_vld;
        n_data    = r_data;
        n_word    = r_word;
        n_opc     = r_opc;
        n_opa     = r_opa;
        n_status  = r_status;
        n_outv    = r_outv;
        ram_we    = 1'b0;
        ram_waddr = r_opa;
        ram_wdata = r_acc;
        ram_raddr = r_opa;
        alu_req   = '{start: 1'b0, op: ALU_ADD};
        alu_b     = mem_word;

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = (i_mode == MODE_STEP) ? r_pc : i_address;
                if (i_in_valid) begin
                    n_status = ST_OK;
                    n_outv   = '0;
                    n_data   = i_data;
                    n_state  = S_DONE;
                    unique case (t_mode'(i_mode))
                        MODE_WRITE: begin
                            if (i_address < MW_LIM) begin
                                ram_we    = 1'b1;
                                ram_waddr = i_address;
                                ram_wdata = i_data;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        MODE_STEP: begin
                            if (!r_run) begin
                                n_status = ST_STOPPED;
                            end else if (r_pc >= MW_LIM) begin
                                n_run    = 1'b0;
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_FETCH;
                            end
                        end
                        MODE_PEEK: begin
                            if (i_address < MW_LIM) begin
                                n_state = S_PEEK;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        MODE_RESTART: begin
                            n_pc  = '0;
                            n_acc = '0;
                            n_run = 1'b1;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_PEEK: begin
                n_outv  = mem_word;
                n_state = S_DONE;
            end
            S_FETCH: begin
                n_word  = mem_word;
                n_state = S_DECODE;
            end
            S_DECODE: begin
                // negative words, opcode zero and anything past halt are unknown
                n_opc   = word_ok ? dec.opc : OP_NONE;
                n_opa   = dec.opa;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (is_mem_op && (r_opa >= MW_LIM)) begin
                    // operand out of range: counter stays put
                    n_run    = 1'b0;
                    n_status = ST_RANGE;
                end else begin
                    n_pc = pc_inc;
                    unique case (r_opc)
                        OP_READ: begin
                            ram_we    = 1'b1;
                            ram_wdata = r_data;
                        end
                        OP_STORE: begin
                            ram_we = 1'b1;
                        end
                        OP_WRITE, OP_LOAD: begin
                            n_state = S_OPER;
                        end
                        OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
                            if (acc_big) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_state = S_OPER;
                            end
                        end
                        OP_BRANCH: begin
                            n_pc = r_opa;
                        end
                        OP_BRNEG: begin
                            if (r_acc[WORD_W-1]) begin
                                n_pc = r_opa;
                            end
                        end
                        OP_BRZERO: begin
                            if (r_acc == '0) begin
                                n_pc = r_opa;
                            end
                        end
                        OP_HALT: begin
                            n_run    = 1'b0;
                            n_status = ST_HALTED;
                        end
                        default: begin
                            n_run    = 1'b0;
                            n_status = ST_BADOP;
                        end
                    endcase
                end
            end
            S_OPER: begin
                n_state = S_ALU;
                unique case (r_opc)
                    OP_WRITE: begin
                        n_outv   = mem_word;
                        n_status = ST_OUTPUT;
                        n_state  = S_DONE;
                    end
                    OP_LOAD: begin
                        n_acc   = mem_word;
                        n_state = S_DONE;
                    end
                    OP_ADD: begin
                        alu_req = '{start: 1'b1, op: ALU_ADD};
                    end
                    OP_SUB: begin
                        alu_req = '{start: 1'b1, op: ALU_SUB};
                    end
                    OP_MUL: begin
                        alu_req = '{start: 1'b1, op: ALU_MUL};
                    end
                    OP_DIV: begin
                        if (mem_word == '0) begin
                            n_status = ST_DIVZERO;
                            n_state  = S_DONE;
                        end else begin
                            alu_req = '{start: 1'b1, op: ALU_DIV};
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ALU: begin
                if (alu_done) begin
                    n_acc   = alu_result;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ram_we) begin
            n_vld[ram_waddr[MA_W-1:0]] = 1'b1;
        end
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_acc   <= '0;
            r_run   <= 1'b1;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_acc   <= n_acc;
            r_run   <= n_run;
            r_vld   <= n_vld;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_word   <= n_word;
        r_opc    <= n_opc;
        r_opa    <= n_opa;
        r_status <= n_status;
        r_outv   <= n_outv;
        r_rd_vld <= r_vld[ram_raddr[MA_W-1:0]];
    end

    // output register, separates the sequencer from a stalled receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_status;
            r_o_value  <= r_outv;
            r_o_pc     <= r_pc;
            r_o_acc    <= r_acc;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_o_status;
    assign o_out_value       = r_o_value;
    assign o_program_counter = r_o_pc;
    assign o_accumulator_now = r_o_acc;

    // one command at a time: accepting a transaction closes the input
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after a transaction");

    // the alu only finishes while the sequencer waits on it
    a_alu_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == S_ALU))
        else $error("alu finished outside its wait state");

    // memory is only written inside the configured depth
    a_ram_we_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr < MW_LIM))
        else $error("memory write beyond configured depth");

    // stepping with the counter out of range stops the machine
    a_pc_range_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_mode == MODE_STEP) && r_run && (r_pc >= MW_LIM))
        |=> !r_run)
        else $error("machine kept running with counter out of range");

    // a new result only appears out of the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result presented without a finished command");

endmodule
